@@ sv/dq_pkg.sv @@
// Shared types and codes for the double-ended queue block.
// Used by dq_ring, dq_out and double_ended_queue; no dependencies.
package dq_pkg;

  // Default ring depth.
  localparam int unsigned DqDepth = 64;

  // Operation codes carried on the request kind field.
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_DUMP       = 3'd4;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // One result on its way to the output side.
  typedef struct packed {
    logic [31:0] data;
    logic [1:0]  status;
    logic        last;
  } dq_res_t;

endpackage

@@ sv/dq_ring.sv @@
// Ring store of the queue: one write port, one read port, registered read.
// Depends on dq_pkg for the default depth.
module dq_ring
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = DqDepth,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; the read data is registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/dq_out.sv @@
// Two-entry output queue that decouples result generation from the master side.
// Depends on dq_pkg for the result type.
module dq_out
  import dq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_i,
  input  dq_res_t     wr_res_i,
  output logic [1:0]  cnt_o,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tuser,   // [1:0] status, zero above
  output logic [31:0] m_tdata,   // [31:0] data
  output logic        m_tlast
);

  dq_res_t    buf_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       pop;
  dq_res_t    head;

  assign pop  = (cnt_q != 2'd0) && m_tready;
  assign head = buf_q[rptr_q];

  // Entry storage; the writer never pushes into a full queue.
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      buf_q[wptr_q] <= wr_res_i;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, wr_i} - {1'b0, pop};
    end
  end

  assign cnt_o    = cnt_q;
  assign m_tvalid = (cnt_q != 2'd0);
  assign m_tdata  = head.data;
  assign m_tuser  = {6'd0, head.status};
  assign m_tlast  = head.last;

  // The queue never holds more than two entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("dq_out: occupancy beyond two");
  // A write into a full queue must coincide with a pop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_i && cnt_q == 2'd2) |-> pop)
    else $error("dq_out: overflow");
  // A stalled head entry keeps its data and last flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && !m_tready) |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("dq_out: head changed while stalled");

endmodule

@@ sv/double_ended_queue.sv @@
// Double-ended queue on a ring store. Push and pop requests can be accepted back to back
// while the output side has room; a result passes the staging register and then the
// two-entry output queue. No request is accepted until a dump has streamed every stored
// element, set by the single read port of the ring. Reset empties the queue at
// once (front and count cleared); ring contents are not cleared and are never read
// before written.
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = DqDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [7:0]  s_tuser,   // [2:0] kind, zero above
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] data
  output logic [7:0]  m_tuser,   // [1:0] status, zero above
  output logic        m_tlast
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic          state_q, state_d;
  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          st_vld_q, st_vld_d;
  logic          st_mem_q, st_mem_d;
  dq_res_t       st_res_q, st_res_d;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   rdata;
  logic [1:0]    ob_cnt;
  logic          pop, room, acc;
  logic [2:0]    pend;
  dq_res_t       wr_res;
  logic [2:0]    kind;

  // Position offset entries behind the front, wrapped to the ring.
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign kind = s_tuser[2:0];
  assign pop  = m_tvalid && m_tready;
  // Room for one more result counting the staged one and the one leaving.
  assign pend = {1'b0, ob_cnt} + {2'b00, st_vld_q} - {2'b00, pop};
  assign room = (pend < 3'd2);
  assign s_tready = (state_q == ST_IDLE) && room;
  assign acc = s_tvalid && s_tready;

  // Request decode, pointer update and dump sequencing.
  always_comb begin
    state_d  = state_q;
    front_d  = front_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    st_vld_d = 1'b0;
    st_mem_d = 1'b0;
    st_res_d = '{data: s_tdata, status: STATUS_OK, last: 1'b1};
    we       = 1'b0;
    waddr    = ring_pos(front_q, cnt_q);
    re       = 1'b0;
    raddr    = front_q;
    if (acc) begin
      unique case (kind) inside
        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
          st_vld_d = 1'b1;
          if (cnt_q >= CW'(DEPTH)) begin
            st_res_d.status = STATUS_FULL;
          end else begin
            we    = 1'b1;
            cnt_d = cnt_q + CW'(1);
            if (kind == KIND_PUSH_FRONT) begin
              front_d = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
              waddr   = front_d;
            end
          end
        end
        KIND_POP_FRONT, KIND_POP_BACK: begin
          st_vld_d = 1'b1;
          if (cnt_q == '0) begin
            st_res_d = '{data: 32'd0, status: STATUS_EMPTY, last: 1'b1};
          end else begin
            re       = 1'b1;
            st_mem_d = 1'b1;
            cnt_d    = cnt_q - CW'(1);
            if (kind == KIND_POP_FRONT) begin
              front_d = ring_pos(front_q, CW'(1));
            end else begin
              raddr = ring_pos(front_q, cnt_q - CW'(1));
            end
          end
        end
        KIND_DUMP: begin
          if (cnt_q == '0) begin
            st_vld_d = 1'b1;
            st_res_d = '{data: 32'd0, status: STATUS_EMPTY, last: 1'b1};
          end else begin
            state_d = ST_DUMP;
            idx_d   = '0;
          end
        end
        default: begin
        end
      endcase
    end else if (state_q == ST_DUMP && room) begin
      // Stream one stored element per cycle while the output queue has room, front to back.
      re              = 1'b1;
      raddr           = ring_pos(front_q, idx_q);
      st_vld_d        = 1'b1;
      st_mem_d        = 1'b1;
      st_res_d.last   = (idx_q == cnt_q - CW'(1));
      idx_d           = idx_q + CW'(1);
      if (st_res_d.last) begin
        state_d = ST_IDLE;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      front_q  <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
      st_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      front_q  <= front_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      st_vld_q <= st_vld_d;
    end
  end

  // Staged result payload; the ring read data is registered at the same edge and joins it here.
  always_ff @(posedge clk_i) begin
    st_mem_q <= st_mem_d;
    st_res_q <= st_res_d;
  end

  always_comb begin
    wr_res = st_res_q;
    if (st_mem_q) begin
      wr_res.data = rdata;
    end
  end

  dq_ring #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(s_tdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  dq_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (st_vld_q),
    .wr_res_i(wr_res),
    .cnt_o   (ob_cnt),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tuser (m_tuser),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  // The element count never exceeds the ring depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(DEPTH))
    else $error("double_ended_queue: count beyond depth");
  // A staged result that takes ring data had a read issued the cycle before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_vld_q && st_mem_q) |-> $past(re))
    else $error("double_ended_queue: ring data without a read");
  // No request is taken while a dump is streaming.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |-> !s_tready)
    else $error("double_ended_queue: request accepted during dump");
  // The element count and front do not change while a dump streams.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |=> $stable(cnt_q) && $stable(front_q))
    else $error("double_ended_queue: state changed during dump");

endmodule

@@ tb/dq_checker.sv @@
// Result checker for the double-ended queue: predicts every result from the accepted
// requests and compares the output stream against it. Depends on dq_pkg only.
`timescale 1ns / 1ps
module dq_checker
  import dq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [7:0]  s_tuser,   // [2:0] kind, zero above
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [31:0] data
  input  logic [7:0]  m_tuser,   // [1:0] status, zero above
  input  logic        m_tlast,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned Depth = DqDepth;

  // Shadow copy of the queue contents and its pointers.
  logic [31:0] ring_mem [Depth];
  logic [5:0]  head_idx;
  logic [6:0]  held_cnt;

  // Results still owed by the block, oldest first.
  dq_res_t     owed_q [$];
  int unsigned mismatches;

  // Updates the shadow queue for one request and queues the results it owes.
  task automatic apply_request(input logic [2:0] kind, input logic [31:0] value);
    int unsigned slot;
    case (kind) inside
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (held_cnt >= Depth) begin
          owed_q.push_back('{data: value, status: STATUS_FULL, last: 1'b1});
        end else begin
          if (kind == KIND_PUSH_FRONT) begin
            head_idx = 6'((head_idx + Depth - 1) % Depth);
            ring_mem[head_idx] = value;
          end else begin
            ring_mem[(head_idx + held_cnt) % Depth] = value;
          end
          held_cnt = held_cnt + 7'd1;
          owed_q.push_back('{data: value, status: STATUS_OK, last: 1'b1});
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (held_cnt == 0) begin
          owed_q.push_back('{data: 32'd0, status: STATUS_EMPTY, last: 1'b1});
        end else begin
          if (kind == KIND_POP_FRONT) begin
            slot = head_idx;
            head_idx = 6'((head_idx + 1) % Depth);
          end else begin
            slot = (head_idx + held_cnt - 1) % Depth;
          end
          held_cnt = held_cnt - 7'd1;
          owed_q.push_back('{data: ring_mem[slot], status: STATUS_OK, last: 1'b1});
        end
      end
      KIND_DUMP: begin
        if (held_cnt == 0) begin
          owed_q.push_back('{data: 32'd0, status: STATUS_EMPTY, last: 1'b1});
        end else begin
          for (int unsigned i = 0; i < held_cnt; i++) begin
            owed_q.push_back('{data: ring_mem[(head_idx + i) % Depth],
                               status: STATUS_OK, last: (i + 1 == held_cnt)});
          end
        end
      end
      default: begin
        // Spare kinds are ignored by the block and owe nothing.
      end
    endcase
  endtask

  // Compares one accepted result against the oldest owed result.
  task automatic check_result();
    dq_res_t want;
    if (owed_q.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result: data %0d status %0d last %0b", $time,
               $signed(m_tdata), m_tuser, m_tlast);
    end else begin
      want = owed_q.pop_front();
      if (m_tdata !== want.data || m_tuser !== {6'd0, want.status} ||
          m_tlast !== want.last) begin
        mismatches++;
        $display("%0t: result mismatch: expected data %0d status %0d last %0b,",
                 $time, $signed(want.data), want.status, want.last,
                 " got data %0d status %0d last %0b",
                 $signed(m_tdata), m_tuser, m_tlast);
      end
    end
  endtask

  // Both channels are sampled at the clock edge that completes their handshake.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_idx = '0;
      held_cnt = '0;
      owed_q.delete();
      pending_o <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_request(s_tuser[2:0], s_tdata);
      end
      if (m_tvalid && m_tready) begin
        check_result();
      end
      pending_o    <= owed_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

@@ tb/tb_double_ended_queue.sv @@
// Top of the double-ended queue testbench: clock, reset, request stimulus and verdict.
// Depends on dq_pkg, double_ended_queue and dq_checker.
`timescale 1ns / 1ps
module tb_double_ended_queue
  import dq_pkg::*;
();

  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned DrainCycles = 80;

  // Kinds the block does not decode.
  localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
  localparam logic [2:0] KIND_SPARE_MID = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI  = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] value
  logic [7:0]  s_tuser;   // [2:0] kind, zero above
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [31:0] data
  logic [7:0]  m_tuser;   // [1:0] status, zero above
  logic        m_tlast;

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  double_ended_queue u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  dq_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  // The result side stalls at random with the current stall percentage.
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offers one request, idling first at random, and returns once it is taken.
  task automatic send_request(input logic [2:0] kind, input logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {5'd0, kind};
    s_tdata  <= value;
    do @(posedge clk_i); while (!s_tready);
  endtask

  // Random element value, with the extremes picked now and then.
  function automatic logic [31:0] random_value();
    logic [31:0] corner [4];
    corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
    if ($urandom_range(7) == 0) begin
      return corner[$urandom_range(3)];
    end
    return $urandom;
  endfunction

  // Fills the queue past full from random ends, dumps it, then drains it past empty.
  task automatic send_fill_drain();
    repeat (DqDepth + 2) begin
      send_request($urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, random_value());
    end
    send_request(KIND_DUMP, random_value());
    repeat (DqDepth + 2) begin
      send_request($urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT, random_value());
    end
  endtask

  // Mixed random traffic, leaning slightly toward pushes.
  task automatic send_mixed(input int unsigned count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 23) begin
        send_request(KIND_PUSH_FRONT, random_value());
      end else if (pick < 46) begin
        send_request(KIND_PUSH_BACK, random_value());
      end else if (pick < 63) begin
        send_request(KIND_POP_FRONT, random_value());
      end else if (pick < 80) begin
        send_request(KIND_POP_BACK, random_value());
      end else if (pick < 92) begin
        send_request(KIND_DUMP, random_value());
      end else begin
        send_request(3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO)), random_value());
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty queue: dump and both pops report empty.
    send_request(KIND_DUMP, 32'h1234_5678);
    send_request(KIND_POP_FRONT, 32'hFFFF_FFFF);
    send_request(KIND_POP_BACK, 32'hFFFF_FFFF);

    // Pushes at both ends with extreme values; the first one wraps the front index.
    send_request(KIND_PUSH_FRONT, 32'h8000_0000);
    send_request(KIND_PUSH_BACK, 32'h7FFF_FFFF);
    send_request(KIND_PUSH_FRONT, 32'h0000_0000);
    send_request(KIND_PUSH_BACK, 32'hFFFF_FFFF);
    send_request(KIND_PUSH_FRONT, 32'h5555_5555);
    send_request(KIND_PUSH_BACK, 32'hAAAA_AAAA);
    send_request(KIND_DUMP, 32'h0);

    // Spare kinds must be ignored without touching the queue.
    send_request(KIND_SPARE_LO, 32'hDEAD_BEEF);
    send_request(KIND_SPARE_MID, 32'h0);
    send_request(KIND_SPARE_HI, 32'hFFFF_FFFF);

    // Pop from both ends down to empty, with dumps in between.
    send_request(KIND_POP_FRONT, 32'h0);
    send_request(KIND_POP_BACK, 32'h0);
    send_request(KIND_DUMP, 32'h0);
    send_request(KIND_POP_FRONT, 32'h0);
    send_request(KIND_POP_BACK, 32'h0);
    send_request(KIND_POP_BACK, 32'h0);
    send_request(KIND_POP_FRONT, 32'h0);
    send_request(KIND_POP_BACK, 32'h0);
    send_request(KIND_DUMP, 32'h0);

    // No idling on either side; full and empty boundaries are crossed here.
    send_fill_drain();
    send_mixed(15);

    // Sender mostly idle.
    send_idle_pct = 88;
    stall_pct     = 0;
    send_mixed(30);

    // Receiver mostly stalled.
    send_idle_pct = 0;
    stall_pct     = 88;
    send_mixed(30);

    // Both sides idle now and then.
    send_idle_pct = 28;
    stall_pct     = 28;
    send_mixed(30);

    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
